>>> design/sis_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sparse integer set.
// No dependencies.
package sis_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int SYM_W        = 8;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 9;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CONTAINS = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;        // capture the input word, issue first read
    logic dense_lookup;  // issue dense read at the sparse entry
    logic finish;        // update the set and load the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lookup;        // incoming word needs the sparse/dense cross-check
  } status_t;

endpackage

>>> design/sis_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/sis_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sparse set: accept, dense lookup, finish; owns output valid.
// Depends on sis_pkg.
module sis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sis_pkg::status_t status,
  output sis_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DENSE = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next       = state;
    cmd.accept       = 1'b0;
    cmd.dense_lookup = 1'b0;
    cmd.finish       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.lookup ? ST_DENSE : ST_DONE;
        end
      end
      ST_DENSE: begin
        cmd.dense_lookup = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        // result register must be free before the set is updated
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> design/sis_dpath.sv
`timescale 1ns / 1ps
// Datapath: sparse and dense arrays, member count, cross-check and result regs.
// Depends on sis_pkg and sis_ram.
module sis_dpath #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sis_pkg::cmd_t                cmd,
  output sis_pkg::status_t             status,
  input  logic [1:0]                   opcode,
  input  logic [sis_pkg::SYM_W-1:0]    symbol,
  input  logic [sis_pkg::POS_W-1:0]    position,
  output logic                         was_member,
  output logic [sis_pkg::COUNT_W-1:0]  set_size,
  output logic [sis_pkg::SYM_W-1:0]    member_symbol,
  output logic                         bad_position
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic [1:0]                  op_r;
  logic [sis_pkg::SYM_W-1:0]   sym_r;
  logic [sis_pkg::POS_W-1:0]   pos_r;
  logic [sis_pkg::COUNT_W-1:0] count, count_next;

  logic [ADDR_W-1:0]         sparse_rdata;
  logic [sis_pkg::SYM_W-1:0] dense_rdata;
  logic [ADDR_W-1:0]         dense_raddr;
  logic                      dense_re;

  logic sym_ok, in_range, hit, pos_ok, do_insert;
  logic was_next, bad_next;
  logic [sis_pkg::SYM_W-1:0] member_next;

  assign status.lookup = (opcode == sis_pkg::OP_ADD) || (opcode == sis_pkg::OP_CONTAINS);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= opcode;
      sym_r <= symbol;
      pos_r <= position;
    end
  end

  // dense port: position read on accept of a dense read, sparse entry read during lookup
  assign dense_re    = (cmd.accept && (opcode == sis_pkg::OP_READ)) || cmd.dense_lookup;
  assign dense_raddr = cmd.dense_lookup ? sparse_rdata : ADDR_W'(32'(position));

  assign sym_ok    = 32'(sym_r) < 32'(CAPACITY);
  assign in_range  = 32'(sparse_rdata) < 32'(count);
  assign hit       = sym_ok && in_range && (dense_rdata == sym_r);
  assign pos_ok    = (32'(pos_r) < 32'(count)) && (32'(pos_r) < 32'(CAPACITY));
  assign do_insert = cmd.finish && (op_r == sis_pkg::OP_ADD) && !hit && sym_ok
                     && (32'(count) < 32'(CAPACITY));

  always_comb begin
    count_next  = count;
    was_next    = 1'b0;
    member_next = '0;
    bad_next    = 1'b0;
    case (op_r)
      sis_pkg::OP_ADD: begin
        was_next = hit;
        if (do_insert) begin
          count_next = count + 1'b1;
        end
      end
      sis_pkg::OP_CONTAINS: was_next = hit;
      sis_pkg::OP_CLEAR:    count_next = '0;
      default: begin
        if (pos_ok) begin
          member_next = dense_rdata;
        end else begin
          bad_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      was_member    <= was_next;
      set_size      <= count_next;
      member_symbol <= member_next;
      bad_position  <= bad_next;
    end
  end

  sis_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (CAPACITY)
  ) u_sparse (
    .clk   (clk),
    .we    (do_insert),
    .waddr (ADDR_W'(32'(sym_r))),
    .wdata (ADDR_W'(count)),
    .re    (cmd.accept),
    .raddr (ADDR_W'(32'(symbol))),
    .rdata (sparse_rdata)
  );

  sis_ram #(
    .WIDTH (sis_pkg::SYM_W),
    .DEPTH (CAPACITY)
  ) u_dense (
    .clk   (clk),
    .we    (do_insert),
    .waddr (ADDR_W'(count)),
    .wdata (sym_r),
    .re    (dense_re),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

endmodule

>>> design/sparse_integer_set.sv
`timescale 1ns / 1ps
// Sparse integer set: add, contains, clear and dense read, one result per word.
// Add/contains step through a sparse RAM read, then a dense RAM read, then the update;
// clear and dense read skip the lookup. One word in flight; a new word is taken
// while the previous result waits in the output register.
// Reset (synchronous) zeroes the member count; array contents need no clearing.
module sparse_integer_set #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [sis_pkg::SYM_W-1:0]    symbol,
  input  logic [sis_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         was_member,
  output logic [sis_pkg::COUNT_W-1:0]  set_size,
  output logic [sis_pkg::SYM_W-1:0]    member_symbol,
  output logic                         bad_position
);

  sis_pkg::cmd_t    cmd;
  sis_pkg::status_t status;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sis_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .symbol        (symbol),
    .position      (position),
    .was_member    (was_member),
    .set_size      (set_size),
    .member_symbol (member_symbol),
    .bad_position  (bad_position)
  );

endmodule
